### sv/coap_pkg.sv
// ----------------------------------------------------------------------------
// coap_pkg
// Shared types and constants for the CoAP message parser: parse phases,
// result kinds and the result record that moves between the parser and the
// result queue.
// ----------------------------------------------------------------------------
package coap_pkg;

    // Option limit: after this many options every later byte is payload
    localparam logic [4:0] MAX_OPTIONS   = 5'd16;
    localparam logic [4:0] OPT_COUNT_SAT = 5'd31;

    // Special byte and nibble codes
    localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0] NIB_EXT8       = 4'd13;
    localparam logic [3:0] NIB_EXT16      = 4'd14;

    // Offsets of the extended delta and length forms
    localparam logic [7:0] EXT8_OFFSET  = 8'd13;
    localparam logic [8:0] EXT16_OFFSET = 9'd269;

    // Result queue depth
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Result kinds
    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_TOKEN   = 3'd1,
        KIND_OPT     = 3'd2,
        KIND_VALUE   = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_END     = 3'd5
    } t_kind;

    // Parse phases, one-hot
    typedef enum logic [10:0] {
        PH_HEADER     = 11'b000_0000_0001,
        PH_TOKEN      = 11'b000_0000_0010,
        PH_OPT_HEAD   = 11'b000_0000_0100,
        PH_DELTA13    = 11'b000_0000_1000,
        PH_DELTA14_HI = 11'b000_0001_0000,
        PH_DELTA14_LO = 11'b000_0010_0000,
        PH_LEN13      = 11'b000_0100_0000,
        PH_LEN14_HI   = 11'b000_1000_0000,
        PH_LEN14_LO   = 11'b001_0000_0000,
        PH_VALUE      = 11'b010_0000_0000,
        PH_PAYLOAD    = 11'b100_0000_0000
    } t_phase;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  code;
        logic [15:0] msg_id;
        logic [15:0] opt_no;
        logic [16:0] opt_len;
        logic [7:0]  data_byte;
        logic        status;
        logic [4:0]  option_count;
        logic        last_of_run;
    } t_result;

    // Results caused by one accepted byte (zero, one or two)
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

### sv/coap_if.sv
// ----------------------------------------------------------------------------
// coap_if
// Valid/ready channels of the parser: the byte input channel and the result
// output channel.
// ----------------------------------------------------------------------------
interface coap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

interface coap_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  code;
    logic [15:0] msg_id;
    logic [15:0] opt_no;
    logic [16:0] opt_len;
    logic [7:0]  data_byte;
    logic        status;
    logic [4:0]  option_count;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output kind, output version, output msg_type, output token_len,
        output code, output msg_id, output opt_no,
        output opt_len, output data_byte, output status,
        output option_count, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input kind, input version, input msg_type, input token_len,
        input code, input msg_id, input opt_no,
        input opt_len, input data_byte, input status,
        input option_count, input last_of_run
    );
endinterface

### sv/coap_parse.sv
// ----------------------------------------------------------------------------
// coap_parse
// Parse state and per-byte decode. On each accepted beat the state advances
// and up to two results are handed to the result queue.
// ----------------------------------------------------------------------------
module coap_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_final,
    output coap_pkg::t_push o_push
);
    import coap_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [1:0]  r_hpos,   n_hpos;
    logic [7:0]  r_fhb,    n_fhb;
    logic [7:0]  r_code,   n_code;
    logic [7:0]  r_idhi,   n_idhi;
    logic [3:0]  r_tok,    n_tok;
    logic [15:0] r_onum,   n_onum;
    logic [3:0]  r_lnib,   n_lnib;
    logic [7:0]  r_exthi,  n_exthi;
    logic [16:0] r_vrem,   n_vrem;
    logic [4:0]  r_opts,   n_opts;

    // Next state and results for the byte at the input
    always_comb begin
        t_result    v_r0;
        t_result    v_end;
        logic       v_has0;
        logic       v_end_hit;
        logic       v_trunc;
        logic       v_take;
        logic       v_start;
        logic [3:0] v_nib;
        logic [16:0] v_len;

        n_phase = r_phase;
        n_hpos  = r_hpos;
        n_fhb   = r_fhb;
        n_code  = r_code;
        n_idhi  = r_idhi;
        n_tok   = r_tok;
        n_onum  = r_onum;
        n_lnib  = r_lnib;
        n_exthi = r_exthi;
        n_vrem  = r_vrem;
        n_opts  = r_opts;

        v_r0      = '0;
        v_end     = '0;
        v_has0    = 1'b0;
        v_end_hit = 1'b0;
        v_trunc   = 1'b0;
        v_take    = 1'b0;
        v_start   = 1'b0;
        v_nib     = r_lnib;
        v_len     = '0;

        unique case (r_phase)
            PH_TOKEN: begin
                v_has0         = 1'b1;
                v_r0.kind      = KIND_TOKEN;
                v_r0.data_byte = i_byte;
                n_tok          = r_tok - 4'd1;
                if (i_final) begin
                    v_end_hit = 1'b1;
                    v_trunc   = (n_tok != 4'd0);
                end else if (n_tok == 4'd0) begin
                    n_phase = PH_OPT_HEAD;
                end
            end
            PH_OPT_HEAD: begin
                if (i_byte == PAYLOAD_MARKER) begin
                    n_phase   = PH_PAYLOAD;
                    v_end_hit = i_final;
                end else begin
                    n_lnib = i_byte[3:0];
                    v_nib  = i_byte[3:0];
                    if (i_byte[7:4] == NIB_EXT8) begin
                        n_phase   = PH_DELTA13;
                        v_end_hit = i_final;
                        v_trunc   = 1'b1;
                    end else if (i_byte[7:4] == NIB_EXT16) begin
                        n_phase   = PH_DELTA14_HI;
                        v_end_hit = i_final;
                        v_trunc   = 1'b1;
                    end else begin
                        n_onum = r_onum + {12'd0, i_byte[7:4]};
                        v_take = 1'b1;
                    end
                end
            end
            PH_DELTA13: begin
                n_onum = r_onum + {8'd0, i_byte} + {8'd0, EXT8_OFFSET};
                v_take = 1'b1;
            end
            PH_DELTA14_HI: begin
                n_exthi   = i_byte;
                n_phase   = PH_DELTA14_LO;
                v_end_hit = i_final;
                v_trunc   = 1'b1;
            end
            PH_DELTA14_LO: begin
                n_onum = r_onum + {r_exthi, i_byte} + {7'd0, EXT16_OFFSET};
                v_take = 1'b1;
            end
            PH_LEN13: begin
                v_start = 1'b1;
                v_len   = {9'd0, i_byte} + {9'd0, EXT8_OFFSET};
            end
            PH_LEN14_HI: begin
                n_exthi   = i_byte;
                n_phase   = PH_LEN14_LO;
                v_end_hit = i_final;
                v_trunc   = 1'b1;
            end
            PH_LEN14_LO: begin
                v_start = 1'b1;
                v_len   = {1'b0, r_exthi, i_byte} + {8'd0, EXT16_OFFSET};
            end
            PH_VALUE: begin
                v_has0         = 1'b1;
                v_r0.kind      = KIND_VALUE;
                v_r0.opt_no    = r_onum;
                v_r0.data_byte = i_byte;
                n_vrem         = r_vrem - 17'd1;
                if (i_final) begin
                    v_end_hit = 1'b1;
                    v_trunc   = (n_vrem != 17'd0);
                end else if (n_vrem != 17'd0) begin
                    n_phase = PH_VALUE;
                end else if (r_opts >= MAX_OPTIONS) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_OPT_HEAD;
                end
            end
            PH_PAYLOAD: begin
                v_has0         = 1'b1;
                v_r0.kind      = KIND_PAYLOAD;
                v_r0.data_byte = i_byte;
                v_end_hit      = i_final;
            end
            PH_HEADER: begin
                unique case (r_hpos)
                    2'd0: n_fhb  = i_byte;
                    2'd1: n_code = i_byte;
                    2'd2: n_idhi = i_byte;
                    default: ;
                endcase
                if (r_hpos == 2'd3) begin
                    // Fourth header byte: header result, header position holds
                    v_has0          = 1'b1;
                    v_r0.kind       = KIND_HEADER;
                    v_r0.version    = r_fhb[7:6];
                    v_r0.msg_type   = r_fhb[5:4];
                    v_r0.token_len  = r_fhb[3:0];
                    v_r0.code       = r_code;
                    v_r0.msg_id     = {r_idhi, i_byte};
                    n_tok           = r_fhb[3:0];
                    n_phase         = (r_fhb[3:0] != 4'd0) ? PH_TOKEN : PH_OPT_HEAD;
                    v_end_hit       = i_final;
                    v_trunc         = (r_fhb[3:0] != 4'd0);
                end else begin
                    n_hpos    = r_hpos + 2'd1;
                    v_end_hit = i_final;
                    v_trunc   = 1'b1;
                end
            end
            default: ;
        endcase

        // Length nibble: extended forms wait for more bytes
        if (v_take) begin
            if (v_nib == NIB_EXT8) begin
                n_phase   = PH_LEN13;
                v_end_hit = i_final;
                v_trunc   = 1'b1;
            end else if (v_nib == NIB_EXT16) begin
                n_phase   = PH_LEN14_HI;
                v_end_hit = i_final;
                v_trunc   = 1'b1;
            end else begin
                v_start = 1'b1;
                v_len   = {13'd0, v_nib};
            end
        end

        // Option start result
        if (v_start) begin
            v_has0       = 1'b1;
            v_r0.kind    = KIND_OPT;
            v_r0.opt_no  = n_onum;
            v_r0.opt_len = v_len;
            if (r_opts < OPT_COUNT_SAT) begin
                n_opts = r_opts + 5'd1;
            end
            n_vrem = v_len;
            if (i_final) begin
                v_end_hit = 1'b1;
                v_trunc   = (v_len != 17'd0);
            end else if (v_len != 17'd0) begin
                n_phase = PH_VALUE;
            end else if (n_opts >= MAX_OPTIONS) begin
                n_phase = PH_PAYLOAD;
            end else begin
                n_phase = PH_OPT_HEAD;
            end
        end

        // End of message: end result, then everything back to reset values
        v_end.kind         = KIND_END;
        v_end.status       = v_trunc;
        v_end.option_count = n_opts;
        v_end.last_of_run  = 1'b1;
        if (v_end_hit) begin
            n_phase = PH_HEADER;
            n_hpos  = '0;
            n_fhb   = '0;
            n_code  = '0;
            n_idhi  = '0;
            n_tok   = '0;
            n_onum  = '0;
            n_lnib  = '0;
            n_exthi = '0;
            n_vrem  = '0;
            n_opts  = '0;
        end

        // Pack the results of this beat
        v_r0.last_of_run = !v_end_hit;
        o_push = '0;
        if (v_has0) begin
            o_push.res0 = v_r0;
            o_push.res1 = v_end;
            o_push.cnt  = v_end_hit ? 2'd2 : 2'd1;
        end else if (v_end_hit) begin
            o_push.res0 = v_end;
            o_push.cnt  = 2'd1;
        end
    end

    // State registers, advanced only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hpos  <= '0;
            r_fhb   <= '0;
            r_code  <= '0;
            r_idhi  <= '0;
            r_tok   <= '0;
            r_onum  <= '0;
            r_lnib  <= '0;
            r_exthi <= '0;
            r_vrem  <= '0;
            r_opts  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hpos  <= n_hpos;
            r_fhb   <= n_fhb;
            r_code  <= n_code;
            r_idhi  <= n_idhi;
            r_tok   <= n_tok;
            r_onum  <= n_onum;
            r_lnib  <= n_lnib;
            r_exthi <= n_exthi;
            r_vrem  <= n_vrem;
            r_opts  <= n_opts;
        end
    end

endmodule

### sv/coap_res_fifo.sv
// ----------------------------------------------------------------------------
// coap_res_fifo
// Small result queue: takes up to two results per cycle, hands out one per
// beat, and reports room for a full two-result push.
// ----------------------------------------------------------------------------
module coap_res_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  coap_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output coap_pkg::t_result o_head
);
    import coap_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr, n_wr;
    logic [FIFO_AW-1:0]     r_rd, n_rd;
    logic [FIFO_CW-1:0]     r_cnt, n_cnt;
    logic [1:0]             n_push;
    logic                   n_pop;

    assign n_push  = i_push_en ? i_push.cnt : 2'd0;
    assign n_pop   = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room  = (r_cnt <= FIFO_CW'(FIFO_DEPTH - 2));

    // Pointer and count updates
    always_comb begin
        n_wr  = r_wr + FIFO_AW'(n_push);
        n_rd  = r_rd + FIFO_AW'(n_pop);
        n_cnt = r_cnt + FIFO_CW'(n_push) - FIFO_CW'(n_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Result storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (n_push == 2'd2) begin
            r_mem[r_wr + FIFO_AW'(1)] <= i_push.res1;
        end
    end

endmodule

### sv/coap_message_parser_top.sv
// The results of a byte are registered in the result queue and offered from its head.
// Throughput: one byte per cycle while the output is ready and each byte yields at most one result;
//   a byte that yields two results (data plus end) puts both into the queue at once.
// Set by the four-entry result queue, which accepts a byte whenever two slots are free.
// Reset: synchronous active-low i_rst_n puts the parser in the header phase
//   and empties the result queue.
// ----------------------------------------------------------------------------
// coap_message_parser_top
// CoAP message parser: bytes in, header, token, option and payload results out.
// ----------------------------------------------------------------------------
module coap_message_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    coap_byte_if.sink   i_in,
    coap_res_if.source  o_res
);
    import coap_pkg::*;

    t_push   w_push;
    t_result w_head;
    logic    w_room;
    logic    w_accept;

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid && w_room;

    // Byte decode and parse state
    coap_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_in.in_byte),
        .i_final  (i_in.final_byte),
        .o_push   (w_push)
    );

    // Result queue toward the output channel
    coap_res_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_accept),
        .i_push    (w_push),
        .o_room    (w_room),
        .o_valid   (o_res.valid),
        .i_pop     (o_res.ready),
        .o_head    (w_head)
    );

    // Output fields
    assign o_res.kind          = w_head.kind;
    assign o_res.version       = w_head.version;
    assign o_res.msg_type      = w_head.msg_type;
    assign o_res.token_len     = w_head.token_len;
    assign o_res.code          = w_head.code;
    assign o_res.msg_id        = w_head.msg_id;
    assign o_res.opt_no        = w_head.opt_no;
    assign o_res.opt_len       = w_head.opt_len;
    assign o_res.data_byte     = w_head.data_byte;
    assign o_res.status        = w_head.status;
    assign o_res.option_count  = w_head.option_count;
    assign o_res.last_of_run   = w_head.last_of_run;

endmodule

### test/tb_coap_message_parser_top.sv
// ----------------------------------------------------------------------------
// tb_coap_message_parser_top
// Drives CoAP messages into the parser one byte per beat and checks every
// result beat against a parse model kept inside the bench. The messages
// include directed corner cases, back-to-back random messages, random
// messages with gaps on both channels, and messages that reach the option
// limit.
// ----------------------------------------------------------------------------
module tb_coap_message_parser_top;
    import coap_pkg::*;

    typedef logic [7:0] t_bytes[$];

    localparam int   CYCLE_LIMIT = 100000;
    localparam int   IDLE_PCT    = 18;
    localparam int   DRAIN_WAIT  = 16;
    localparam int   MAX_REPORTS = 10;
    localparam logic ST_OK       = 1'b0;
    localparam logic ST_TRUNC    = 1'b1;
    localparam logic MORE        = 1'b0;
    localparam logic LAST        = 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   gaps_on = 1'b1;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   errors = 0;

    coap_byte_if byte_ch();
    coap_res_if  res_ch();

    coap_message_parser_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_res   (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // Parse model state
    t_phase      ph;
    logic [1:0]  hdr_pos;
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_code;
    logic [7:0]  mid_hi;
    logic [3:0]  tok_left;
    logic [15:0] opt_num;
    logic [3:0]  len_nib;
    logic [7:0]  ext_hi;
    logic [16:0] val_left;
    logic [4:0]  opts_seen;

    t_result byte_results[$];   // results of the byte being parsed
    t_result due_results[$];    // results not yet seen on the output

    function automatic t_result empty_result(input t_kind k);
        t_result r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    task automatic clear_parser();
        ph        = PH_HEADER;
        hdr_pos   = '0;
        hdr_first = '0;
        hdr_code  = '0;
        mid_hi    = '0;
        tok_left  = '0;
        opt_num   = '0;
        len_nib   = '0;
        ext_hi    = '0;
        val_left  = '0;
        opts_seen = '0;
    endtask

    // End of message: report and return to the header phase
    task automatic emit_end(input logic status);
        t_result r;
        r = empty_result(KIND_END);
        r.status       = status;
        r.option_count = opts_seen;
        byte_results.push_back(r);
        clear_parser();
    endtask

    task automatic after_option();
        if (val_left != 0)
            ph = PH_VALUE;
        else if (opts_seen >= MAX_OPTIONS)
            ph = PH_PAYLOAD;
        else
            ph = PH_OPT_HEAD;
    endtask

    task automatic start_option(input logic [16:0] len, input logic fin);
        t_result r;
        r = empty_result(KIND_OPT);
        r.opt_no  = opt_num;
        r.opt_len = len;
        byte_results.push_back(r);
        if (opts_seen < OPT_COUNT_SAT)
            opts_seen = opts_seen + 5'd1;
        val_left = len;
        if (fin)
            emit_end((val_left != 0) ? ST_TRUNC : ST_OK);
        else
            after_option();
    endtask

    task automatic take_length(input logic [3:0] l, input logic fin);
        if (l == NIB_EXT8) begin
            ph = PH_LEN13;
            if (fin) emit_end(ST_TRUNC);
        end else if (l == NIB_EXT16) begin
            ph = PH_LEN14_HI;
            if (fin) emit_end(ST_TRUNC);
        end else begin
            start_option(17'(l), fin);
        end
    endtask

    // Advance the model by one accepted byte and queue what it yields
    task automatic parse_byte(input logic [7:0] in_b, input logic fin);
        t_result    r;
        logic [3:0] d;
        byte_results.delete();
        case (ph)
            PH_TOKEN: begin
                r = empty_result(KIND_TOKEN);
                r.data_byte = in_b;
                byte_results.push_back(r);
                tok_left = tok_left - 4'd1;
                if (fin)
                    emit_end((tok_left != 0) ? ST_TRUNC : ST_OK);
                else if (tok_left == 0)
                    ph = PH_OPT_HEAD;
            end
            PH_OPT_HEAD: begin
                if (in_b == PAYLOAD_MARKER) begin
                    ph = PH_PAYLOAD;
                    if (fin) emit_end(ST_OK);
                end else begin
                    d       = in_b[7:4];
                    len_nib = in_b[3:0];
                    if (d == NIB_EXT8) begin
                        ph = PH_DELTA13;
                        if (fin) emit_end(ST_TRUNC);
                    end else if (d == NIB_EXT16) begin
                        ph = PH_DELTA14_HI;
                        if (fin) emit_end(ST_TRUNC);
                    end else begin
                        opt_num = opt_num + 16'(d);
                        take_length(len_nib, fin);
                    end
                end
            end
            PH_DELTA13: begin
                opt_num = opt_num + 16'(in_b) + 16'(EXT8_OFFSET);
                take_length(len_nib, fin);
            end
            PH_DELTA14_HI: begin
                ext_hi = in_b;
                ph     = PH_DELTA14_LO;
                if (fin) emit_end(ST_TRUNC);
            end
            PH_DELTA14_LO: begin
                opt_num = opt_num + {ext_hi, in_b} + 16'(EXT16_OFFSET);
                take_length(len_nib, fin);
            end
            PH_LEN13: begin
                start_option(17'(in_b) + 17'(EXT8_OFFSET), fin);
            end
            PH_LEN14_HI: begin
                ext_hi = in_b;
                ph     = PH_LEN14_LO;
                if (fin) emit_end(ST_TRUNC);
            end
            PH_LEN14_LO: begin
                start_option(17'({ext_hi, in_b}) + 17'(EXT16_OFFSET), fin);
            end
            PH_VALUE: begin
                r = empty_result(KIND_VALUE);
                r.opt_no    = opt_num;
                r.data_byte = in_b;
                byte_results.push_back(r);
                val_left = val_left - 17'd1;
                if (fin)
                    emit_end((val_left != 0) ? ST_TRUNC : ST_OK);
                else
                    after_option();
            end
            PH_PAYLOAD: begin
                r = empty_result(KIND_PAYLOAD);
                r.data_byte = in_b;
                byte_results.push_back(r);
                if (fin) emit_end(ST_OK);
            end
            default: begin
                ph = PH_HEADER;
                if (hdr_pos == 2'd3) begin
                    r = empty_result(KIND_HEADER);
                    r.version    = hdr_first[7:6];
                    r.msg_type   = hdr_first[5:4];
                    r.token_len  = hdr_first[3:0];
                    r.code       = hdr_code;
                    r.msg_id     = {mid_hi, in_b};
                    byte_results.push_back(r);
                    tok_left = hdr_first[3:0];
                    ph = (tok_left != 0) ? PH_TOKEN : PH_OPT_HEAD;
                    if (fin) emit_end((tok_left != 0) ? ST_TRUNC : ST_OK);
                end else begin
                    case (hdr_pos)
                        2'd0:    hdr_first = in_b;
                        2'd1:    hdr_code  = in_b;
                        default: mid_hi    = in_b;
                    endcase
                    hdr_pos = hdr_pos + 2'd1;
                    if (fin) emit_end(ST_TRUNC);
                end
            end
        endcase
        // last result of this byte carries the run flag
        if (byte_results.size() > 0) begin
            r = byte_results.pop_back();
            r.last_of_run = 1'b1;
            byte_results.push_back(r);
        end
        foreach (byte_results[i]) due_results.push_back(byte_results[i]);
    endtask

    // Send one byte; the input is left valid until the next call decides
    task automatic send_byte(input logic [7:0] in_b, input logic fin);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                byte_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        byte_ch.valid      <= 1'b1;
        byte_ch.in_byte    <= in_b;
        byte_ch.final_byte <= fin;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        parse_byte(in_b, fin);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input t_bytes msg);
        foreach (msg[i]) send_byte(msg[i], (i == msg.size() - 1) ? LAST : MORE);
    endtask

    // Well-formed message with random content, sometimes cut short
    function automatic t_bytes random_message(input bit many_options);
        t_bytes     m;
        int         tkl;
        int         n_opts;
        int         dlen;
        logic [1:0] ver;
        logic [3:0] dn;
        logic [3:0] ln;
        logic [7:0] lb;
        logic [7:0] hb;
        bit         cut;
        cut = 1'b0;
        tkl = ($urandom_range(9) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
        ver = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'd1;
        m.push_back({ver, 2'($urandom_range(3)), 4'(tkl)});
        repeat (3) m.push_back(8'($urandom_range(255)));
        repeat (tkl) m.push_back(8'($urandom_range(255)));
        n_opts = many_options ? $urandom_range(19, 15) : $urandom_range(5);
        for (int i = 0; i < n_opts; i++) begin
            case ($urandom_range(9))
                0:       dn = NIB_EXT8;
                1:       dn = NIB_EXT16;
                2:       dn = 4'd15;
                default: dn = 4'($urandom_range(12));
            endcase
            case ($urandom_range(19))
                0, 1:    ln = NIB_EXT8;
                2:       ln = NIB_EXT16;
                3:       ln = 4'd15;
                default: ln = 4'($urandom_range(4));
            endcase
            // nibbles 15/15 would read as the payload marker
            if (dn == 4'd15 && ln == 4'd15) ln = 4'd0;
            m.push_back({dn, ln});
            if (dn == NIB_EXT8) m.push_back(8'($urandom_range(255)));
            if (dn == NIB_EXT16) begin
                hb = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
                m.push_back(hb);
                m.push_back(8'($urandom_range(255)));
            end
            if (ln == NIB_EXT8) begin
                lb = 8'($urandom_range(3));
                m.push_back(lb);
                dlen = int'(lb) + int'(EXT8_OFFSET);
            end else if (ln == NIB_EXT16) begin
                hb = 8'($urandom_range(255));
                lb = 8'($urandom_range(255));
                m.push_back(hb);
                m.push_back(lb);
                dlen = int'({hb, lb}) + int'(EXT16_OFFSET);
            end else begin
                dlen = int'(ln);
            end
            // long values end the message part way through
            if (dlen > 24) begin
                repeat ($urandom_range(24, 1)) m.push_back(8'($urandom_range(255)));
                cut = 1'b1;
                break;
            end
            repeat (dlen) m.push_back(8'($urandom_range(255)));
        end
        if (!cut && $urandom_range(1) == 1) begin
            m.push_back(PAYLOAD_MARKER);
            repeat ($urandom_range(6)) m.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(9) == 0) m = m[0:$urandom_range(m.size() - 1)];
        return m;
    endfunction

    function automatic t_bytes noise_message();
        t_bytes m;
        repeat ($urandom_range(12, 1)) m.push_back(8'($urandom_range(255)));
        return m;
    endfunction

    // Directed corner cases
    task automatic test_short_header();
        send_byte(8'h7A, MORE);
        send_byte(8'h45, LAST);
    endtask

    task automatic test_token_cut();
        repeat (3) send_byte(8'hFF, MORE);
        send_byte(8'hFF, LAST);
    endtask

    task automatic test_marker_last();
        repeat (4) send_byte(8'h00, MORE);
        send_byte(PAYLOAD_MARKER, LAST);
    endtask

    task automatic test_extension_cut();
        send_byte(8'h50, MORE);
        send_byte(8'h01, MORE);
        send_byte(8'hAB, MORE);
        send_byte(8'hCD, MORE);
        send_byte(8'hD3, LAST);
    endtask

    // delta 15 / length 2 nibbles, then a value byte on the final beat
    task automatic test_nibble15_value_cut();
        send_byte(8'h60, MORE);
        repeat (3) send_byte(8'h00, MORE);
        send_byte(8'hF2, MORE);
        send_byte(8'h5A, LAST);
    endtask

    // widest delta twice (number wraps) and widest length
    task automatic test_wrap_and_max_length();
        send_byte(8'h40, MORE);
        repeat (3) send_byte(8'h00, MORE);
        send_byte(8'hE0, MORE);
        send_byte(8'hFF, MORE);
        send_byte(8'hFF, MORE);
        send_byte(8'hEE, MORE);
        repeat (4) send_byte(8'hFF, MORE);
        send_byte(8'h00, LAST);
    endtask

    task automatic test_back_to_back(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        gaps_on = 1'b0;
        while (bytes_sent < stop_at) send_message(random_message(1'b0));
        gaps_on = 1'b1;
    endtask

    task automatic test_random_messages(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 15)
                send_message(noise_message());
            else
                send_message(random_message(1'b0));
        end
    endtask

    task automatic test_option_limit();
        repeat (2) send_message(random_message(1'b1));
    endtask

    // Result sink stalls
    always @(negedge i_clk) begin
        res_ch.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic string describe(input t_result r);
        return $sformatf("kind=%0d ver=%0d type=%0d tkl=%0d code=%02h mid=%04h %s",
                         r.kind, r.version, r.msg_type, r.token_len, r.code,
                         r.msg_id,
                         $sformatf("onum=%0d olen=%0d data=%02h st=%0d cnt=%0d last=%0d",
                                   r.opt_no, r.opt_len, r.data_byte,
                                   r.status, r.option_count, r.last_of_run));
    endfunction

    function automatic string field_diffs(input t_result a, input t_result e);
        string s = "";
        if (a.kind !== e.kind)                   s = {s, " kind"};
        if (a.version !== e.version)             s = {s, " version"};
        if (a.msg_type !== e.msg_type)           s = {s, " msg_type"};
        if (a.token_len !== e.token_len)         s = {s, " token_len"};
        if (a.code !== e.code)                   s = {s, " code"};
        if (a.msg_id !== e.msg_id)               s = {s, " msg_id"};
        if (a.opt_no !== e.opt_no)               s = {s, " opt_no"};
        if (a.opt_len !== e.opt_len)             s = {s, " opt_len"};
        if (a.data_byte !== e.data_byte)         s = {s, " data_byte"};
        if (a.status !== e.status)               s = {s, " status"};
        if (a.option_count !== e.option_count)   s = {s, " option_count"};
        if (a.last_of_run !== e.last_of_run)     s = {s, " last_of_run"};
        return s;
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Result checker
    t_result seen_result;
    t_result head_result;
    string   diff_list;

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen_result.kind          = t_kind'(res_ch.kind);
            seen_result.version       = res_ch.version;
            seen_result.msg_type      = res_ch.msg_type;
            seen_result.token_len     = res_ch.token_len;
            seen_result.code          = res_ch.code;
            seen_result.msg_id        = res_ch.msg_id;
            seen_result.opt_no        = res_ch.opt_no;
            seen_result.opt_len       = res_ch.opt_len;
            seen_result.data_byte     = res_ch.data_byte;
            seen_result.status        = res_ch.status;
            seen_result.option_count  = res_ch.option_count;
            seen_result.last_of_run   = res_ch.last_of_run;
            if (due_results.size() == 0) begin
                note_error({"unexpected result: ", describe(seen_result)});
            end else begin
                head_result = due_results.pop_front();
                diff_list   = field_diffs(seen_result, head_result);
                if (diff_list != "")
                    note_error({"mismatch in", diff_list,
                                "\n  expected ", describe(head_result),
                                "\n  actual   ", describe(seen_result)});
            end
        end
    end

    // Run time limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.in_byte    = 8'h00;
        byte_ch.final_byte = 1'b0;
        res_ch.ready       = 1'b0;
        clear_parser();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_header();
        test_token_cut();
        test_marker_last();
        test_extension_cut();
        test_nibble15_value_cut();
        test_wrap_and_max_length();
        test_back_to_back(70);
        test_random_messages(140);
        test_option_limit();

        byte_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
sv/coap_pkg.sv
sv/coap_if.sv
sv/coap_parse.sv
sv/coap_res_fifo.sv
sv/coap_message_parser_top.sv
test/tb_coap_message_parser_top.sv
